>>> sv/pfra_pkg.sv
`timescale 1ns / 1ps

package pfra_pkg;

    localparam int FRAMES     = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int WORD_BITS  = 64;
    localparam int WORD_W     = $clog2(WORD_BITS);
    localparam int WORDS      = FRAMES / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORDS);
    localparam int CFG_IDX_W  = 1;

    localparam logic [ADDR_W-1:0]  LOW_BASE         = 32'h0010_0000;
    localparam logic [ADDR_W-1:0]  MAIN_START_RESET = 32'h0040_0000;
    localparam logic [ADDR_W-1:0]  HIGH_MEM_RESET   = 32'h0100_0000;
    localparam logic [COUNT_W-1:0] RESERVED_MARK    = 8'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_MAIN_START  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MEMORY = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_ADDREF = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_OOM    = 3'd1,
        ST_BELOW  = 3'd2,
        ST_BEYOND = 3'd3,
        ST_FREE   = 3'd4,
        ST_SAT    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SWEEP,
        S_CHECK,
        S_UPD,
        S_ALLOC,
        S_ALLOC_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 cnt_we;
        logic [FRAME_W-1:0]   cnt_addr;
        logic [COUNT_W-1:0]   cnt_data;
        logic                 map_we;
        logic [WIDX_W-1:0]    map_addr;
        logic [WORD_BITS-1:0] map_data;
        logic                 done;
    } sweep_wr_t;

    function automatic logic [WORD_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WORD_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] first_word(input logic [WORDS-1:0] v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WIDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> sv/pfra_ifs.sv
`timescale 1ns / 1ps

interface pfra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] address;
    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

interface pfra_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] page_address;
    logic [2:0]  status;
    logic [7:0]  new_count;
    modport source (output valid, output page_address, output status, output new_count,
                    input ready);
    modport sink (input valid, input page_address, input status, input new_count,
                  output ready);
endinterface

interface pfra_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/pfra_ram.sv
`timescale 1ns / 1ps

module pfra_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pfra_sweep.sv
`timescale 1ns / 1ps

module pfra_sweep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfra_pkg::PFN_W-1:0]  first,
    input  logic [pfra_pkg::PFN_W:0]    stop,
    output pfra_pkg::sweep_wr_t         wr
);

    logic                               active_reg, active_next;
    logic [pfra_pkg::FRAME_W-1:0]       idx_reg, idx_next;
    logic [pfra_pkg::WORD_BITS-1:0]     acc_reg, acc_next;
    logic [pfra_pkg::PFN_W:0]           idx_ext;
    logic                               in_range;
    logic                               last;
    logic [pfra_pkg::WORD_BITS-1:0]     word;

    assign idx_ext  = (pfra_pkg::PFN_W + 1)'(idx_reg);
    assign in_range = (idx_ext >= {1'b0, first}) && (idx_ext < stop);
    assign last     = idx_reg == pfra_pkg::FRAME_W'(pfra_pkg::FRAMES - 1);

    always_comb
    begin
        word = acc_reg;
        word[idx_reg[pfra_pkg::WORD_W-1:0]] = in_range;
    end

    always_comb
    begin
        wr.cnt_we   = active_reg;
        wr.cnt_addr = idx_reg;
        wr.cnt_data = in_range ? '0 : pfra_pkg::RESERVED_MARK;
        wr.map_we   = active_reg && (&idx_reg[pfra_pkg::WORD_W-1:0]);
        wr.map_addr = idx_reg[pfra_pkg::FRAME_W-1:pfra_pkg::WORD_W];
        wr.map_data = word;
        wr.done     = active_reg && last;
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            acc_next    = '0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
            acc_next = (&idx_reg[pfra_pkg::WORD_W-1:0]) ? '0 : word;
            if (last)
            begin
                active_next = 1'b0;
            end
        end
    end

    // reset starts the clearing pass straight away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

>>> sv/page_frame_refcount_allocator.sv
`timescale 1ns / 1ps
// free and add reference: check, update, done; no update below the base or outside the table
// alloc: alloc, alloc write, done; no write when no frame is free; init: setup, sweep, done
// throughput: one request at a time, set by the read-modify-write of the count and map rams
// alloc takes the lowest free word from a summary register, then the lowest bit of that word
// reset: asynchronous, active low; a clearing pass over all FRAMES (4096) frames marks every
// frame reserved, with no request taken until it ends; configuration writes are taken always
module page_frame_refcount_allocator (
    input  logic        clk,
    input  logic        rst_n,
    pfra_req_if.sink    req,
    pfra_rsp_if.source  rsp,
    pfra_cfg_if.sink    cfg
);

    pfra_pkg::state_t                    state_reg, state_next;
    logic [pfra_pkg::ADDR_W-1:0]         main_start_reg, main_start_next;
    logic [pfra_pkg::ADDR_W-1:0]         high_memory_reg, high_memory_next;
    pfra_pkg::op_t                       op_reg, op_next;
    logic [pfra_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [pfra_pkg::FRAME_W-1:0]        idx_reg, idx_next;
    logic                                beyond_reg, beyond_next;
    logic [pfra_pkg::WIDX_W-1:0]         w_reg, w_next;
    logic [pfra_pkg::PFN_W-1:0]          first_reg, first_next;
    logic [pfra_pkg::PFN_W-1:0]          npg_reg, npg_next;
    logic [pfra_pkg::PFN_W:0]            stop_reg, stop_next;
    logic [pfra_pkg::WORDS-1:0]          summary_reg, summary_next;
    logic [pfra_pkg::ADDR_W-1:0]         res_page_reg, res_page_next;
    pfra_pkg::status_t                   res_status_reg, res_status_next;
    logic [pfra_pkg::COUNT_W-1:0]        res_count_reg, res_count_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    logic [pfra_pkg::ADDR_W-1:0]         rsp_page_reg;
    pfra_pkg::status_t                   rsp_status_reg;
    logic [pfra_pkg::COUNT_W-1:0]        rsp_count_reg;

    logic                                accept;
    logic                                out_free;
    logic                                rsp_load;
    logic                                sweep_start;
    pfra_pkg::sweep_wr_t                 sw;

    logic                                cnt_we;
    logic [pfra_pkg::FRAME_W-1:0]        cnt_waddr, cnt_raddr;
    logic [pfra_pkg::COUNT_W-1:0]        cnt_wdata, cnt_rd;
    logic                                map_we;
    logic [pfra_pkg::WIDX_W-1:0]         map_waddr, map_raddr;
    logic [pfra_pkg::WORD_BITS-1:0]      map_wdata, map_rd;

    logic                                below;
    logic [pfra_pkg::ADDR_W-1:0]         off;
    logic [pfra_pkg::PFN_W-1:0]          pfn;
    logic                                in_table;
    logic [pfra_pkg::FRAME_W-1:0]        chk_idx;

    logic [pfra_pkg::ADDR_W-1:0]         eff;
    logic [pfra_pkg::ADDR_W-1:0]         eoff;
    logic [pfra_pkg::ADDR_W-1:0]         span;
    logic [pfra_pkg::PFN_W-1:0]          init_npg;

    logic [pfra_pkg::WIDX_W-1:0]         alloc_w;
    logic [pfra_pkg::WORD_W-1:0]         alloc_b;
    logic [pfra_pkg::FRAME_W-1:0]        alloc_idx;
    logic [pfra_pkg::WORD_BITS-1:0]      alloc_word;

    logic [pfra_pkg::COUNT_W-1:0]        upd_count;
    pfra_pkg::status_t                   upd_status;
    logic [pfra_pkg::WORD_BITS-1:0]      upd_word;

    pfra_sweep u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sweep_start),
        .first (first_reg),
        .stop  (stop_reg),
        .wr    (sw)
    );

    pfra_ram #(
        .DEPTH (pfra_pkg::FRAMES),
        .WIDTH (pfra_pkg::COUNT_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    // one bit per frame, set while its count is zero
    pfra_ram #(
        .DEPTH (pfra_pkg::WORDS),
        .WIDTH (pfra_pkg::WORD_BITS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rd)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = state_reg == pfra_pkg::S_IDLE;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.page_address = rsp_page_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.new_count    = rsp_count_reg;

    always_comb
    begin
        main_start_next  = main_start_reg;
        high_memory_next = high_memory_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pfra_pkg::REG_MAIN_START:  main_start_next  = cfg.data;
                pfra_pkg::REG_HIGH_MEMORY: high_memory_next = cfg.data;
                default: ;
            endcase
        end
    end

    // address checks for free and add reference
    assign below    = addr_reg < pfra_pkg::LOW_BASE;
    assign off      = addr_reg - pfra_pkg::LOW_BASE;
    assign pfn      = off[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
    assign in_table = pfn < pfra_pkg::PFN_W'(pfra_pkg::FRAMES);
    assign chk_idx  = pfn[pfra_pkg::FRAME_W-1:0];

    // init range from the configuration
    assign eff      = (main_start_reg > pfra_pkg::LOW_BASE) ? main_start_reg
                                                            : pfra_pkg::LOW_BASE;
    assign eoff     = eff - pfra_pkg::LOW_BASE;
    assign span     = high_memory_reg - eff;
    assign init_npg = (high_memory_reg > eff) ? span[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT]
                                              : '0;

    assign alloc_w   = pfra_pkg::first_word(summary_reg);
    assign alloc_b   = pfra_pkg::first_bit(map_rd);
    assign alloc_idx = {w_reg, alloc_b};

    always_comb
    begin
        alloc_word          = map_rd;
        alloc_word[alloc_b] = 1'b0;
    end

    always_comb
    begin
        upd_status = pfra_pkg::ST_OK;
        upd_count  = cnt_rd;
        if (op_reg == pfra_pkg::OP_FREE)
        begin
            if (cnt_rd == '0)
            begin
                upd_status = pfra_pkg::ST_FREE;
            end
            else
            begin
                upd_count = cnt_rd - 1'b1;
            end
        end
        else
        begin
            if (cnt_rd == pfra_pkg::COUNT_MAX)
            begin
                upd_status = pfra_pkg::ST_SAT;
            end
            else
            begin
                upd_count = cnt_rd + 1'b1;
            end
        end
        if (beyond_reg)
        begin
            upd_status = pfra_pkg::ST_BEYOND;
        end
        upd_word = map_rd;
        upd_word[idx_reg[pfra_pkg::WORD_W-1:0]] = upd_count == '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfra_pkg::S_CLEAR:
            begin
                if (sw.done)
                begin
                    state_next = pfra_pkg::S_IDLE;
                end
            end
            pfra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (pfra_pkg::op_t'(req.op)) inside
                        pfra_pkg::OP_INIT:                     state_next = pfra_pkg::S_SETUP;
                        pfra_pkg::OP_ALLOC:                    state_next = pfra_pkg::S_ALLOC;
                        pfra_pkg::OP_FREE, pfra_pkg::OP_ADDREF: state_next = pfra_pkg::S_CHECK;
                        default:                               state_next = pfra_pkg::S_CHECK;
                    endcase
                end
            end
            pfra_pkg::S_SETUP:
            begin
                state_next = pfra_pkg::S_SWEEP;
            end
            pfra_pkg::S_SWEEP:
            begin
                if (sw.done)
                begin
                    state_next = pfra_pkg::S_DONE;
                end
            end
            pfra_pkg::S_CHECK:
            begin
                state_next = (below || !in_table) ? pfra_pkg::S_DONE : pfra_pkg::S_UPD;
            end
            pfra_pkg::S_UPD:
            begin
                state_next = pfra_pkg::S_DONE;
            end
            pfra_pkg::S_ALLOC:
            begin
                state_next = (summary_reg == '0) ? pfra_pkg::S_DONE : pfra_pkg::S_ALLOC_WR;
            end
            pfra_pkg::S_ALLOC_WR:
            begin
                state_next = pfra_pkg::S_DONE;
            end
            pfra_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pfra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfra_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        beyond_next     = beyond_reg;
        w_next          = w_reg;
        first_next      = first_reg;
        npg_next        = npg_reg;
        stop_next       = stop_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        sweep_start     = 1'b0;
        rsp_load        = 1'b0;
        cnt_we          = sw.cnt_we;
        cnt_waddr       = sw.cnt_addr;
        cnt_wdata       = sw.cnt_data;
        map_we          = sw.map_we;
        map_waddr       = sw.map_addr;
        map_wdata       = sw.map_data;
        cnt_raddr       = chk_idx;
        map_raddr       = chk_idx[pfra_pkg::FRAME_W-1:pfra_pkg::WORD_W];
        unique case (state_reg)
            pfra_pkg::S_CLEAR: ;
            pfra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = pfra_pkg::op_t'(req.op);
                    addr_next  = req.address;
                    first_next = eoff[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
                    npg_next   = init_npg;
                end
            end
            pfra_pkg::S_SETUP:
            begin
                stop_next   = {1'b0, first_reg} + {1'b0, npg_reg};
                sweep_start = 1'b1;
            end
            pfra_pkg::S_SWEEP:
            begin
                res_page_next   = '0;
                res_status_next = pfra_pkg::ST_OK;
                res_count_next  = '0;
            end
            pfra_pkg::S_CHECK:
            begin
                idx_next        = chk_idx;
                beyond_next     = addr_reg > high_memory_reg;
                res_page_next   = '0;
                res_count_next  = '0;
                res_status_next = below ? pfra_pkg::ST_BELOW : pfra_pkg::ST_BEYOND;
            end
            pfra_pkg::S_UPD:
            begin
                cnt_we          = 1'b1;
                cnt_waddr       = idx_reg;
                cnt_wdata       = upd_count;
                map_we          = 1'b1;
                map_waddr       = idx_reg[pfra_pkg::FRAME_W-1:pfra_pkg::WORD_W];
                map_wdata       = upd_word;
                res_page_next   = '0;
                res_status_next = upd_status;
                res_count_next  = upd_count;
            end
            pfra_pkg::S_ALLOC:
            begin
                map_raddr       = alloc_w;
                w_next          = alloc_w;
                res_page_next   = '0;
                res_status_next = pfra_pkg::ST_OOM;
                res_count_next  = '0;
            end
            pfra_pkg::S_ALLOC_WR:
            begin
                cnt_we          = 1'b1;
                cnt_waddr       = alloc_idx;
                cnt_wdata       = pfra_pkg::COUNT_W'(1);
                map_we          = 1'b1;
                map_waddr       = w_reg;
                map_wdata       = alloc_word;
                res_page_next   = pfra_pkg::LOW_BASE
                                + (pfra_pkg::ADDR_W'(alloc_idx) << pfra_pkg::PAGE_SHIFT);
                res_status_next = pfra_pkg::ST_OK;
                res_count_next  = pfra_pkg::COUNT_W'(1);
            end
            pfra_pkg::S_DONE:
            begin
                rsp_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        summary_next = summary_reg;
        if (map_we)
        begin
            summary_next[map_waddr] = |map_wdata;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfra_pkg::S_CLEAR;
            main_start_reg  <= pfra_pkg::MAIN_START_RESET;
            high_memory_reg <= pfra_pkg::HIGH_MEM_RESET;
            first_reg       <= '0;
            npg_reg         <= '0;
            stop_reg        <= '0;
            summary_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            main_start_reg  <= main_start_next;
            high_memory_reg <= high_memory_next;
            first_reg       <= first_next;
            npg_reg         <= npg_next;
            stop_reg        <= stop_next;
            summary_reg     <= summary_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        beyond_reg     <= beyond_next;
        w_reg          <= w_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        if (rsp_load)
        begin
            rsp_page_reg   <= res_page_reg;
            rsp_status_reg <= res_status_reg;
            rsp_count_reg  <= res_count_reg;
        end
    end

    a_sweep_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sw.cnt_we |-> (state_reg == pfra_pkg::S_CLEAR || state_reg == pfra_pkg::S_SWEEP))
        else $error("sweep write outside a sweep");

    a_alloc_word_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfra_pkg::S_ALLOC_WR |-> map_rd != '0)
        else $error("summary points at a word with no free frame");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == pfra_pkg::S_DONE)
        else $error("response raised outside done");

    a_idle_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfra_pkg::S_CLEAR && sw.done) |=> state_reg == pfra_pkg::S_IDLE)
        else $error("clearing pass did not hand over to idle");

endmodule
